/* rtl/lrukv_pkg.sv */
// Shared types and constants for the LRU key-value cache.
package lrukv_pkg;

  localparam int KEY_W          = 32;
  localparam int VAL_W          = 32;
  localparam int CAP_W          = 5;
  localparam int DEFAULT_ENTRIES = 16;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  typedef enum logic {
    MODE_GET = 1'b0,
    MODE_PUT = 1'b1
  } mode_e;

  // One request held in the input register
  typedef struct packed {
    logic             valid;
    mode_e            mode;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } req_t;

  // Lookup outcome handed from the store to the result register
  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
  } rsp_t;

endpackage

/* rtl/lrukv_store.sv */
// Entry storage, parallel key compare and recency rank update.
module lrukv_store #(
  parameter int ENTRIES = lrukv_pkg::DEFAULT_ENTRIES
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [lrukv_pkg::CAP_W-1:0] cfg_wdata_i,
  input  lrukv_pkg::req_t        req_i,
  output lrukv_pkg::rsp_t        rsp_o
);
  import lrukv_pkg::*;

  localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  logic [KEY_W-1:0]  key_q  [ENTRIES];
  logic [VAL_W-1:0]  val_q  [ENTRIES];
  logic [RANK_W-1:0] rank_q [ENTRIES];
  logic [RANK_W-1:0] rank_d [ENTRIES];
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [OCC_W-1:0]  occ_q, occ_d;
  logic [CAP_W-1:0]  cap_q;

  logic [ENTRIES-1:0] hit_sel, free_sel, lru_sel, ins_sel;
  logic [RANK_W-1:0]  hit_rank, lru_rank;
  logic [CMP_W-1:0]   cap_ext, eff_cap;
  logic               hit, full, do_insert, do_evict, put_hit;
  logic [VAL_W-1:0]   hit_val;
  logic [KEY_W-1:0]   lru_key;

  // Clamp capacity to the range one to ENTRIES
  always_comb begin
    cap_ext = CMP_W'(cap_q);
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign full     = CMP_W'(occ_q) >= eff_cap;
  // Valid ranks are always a permutation of 0..occupancy-1
  assign lru_rank = RANK_W'(occ_q - OCC_W'(1));

  // Compare all keys, pick first hit, first free slot and the oldest entry
  always_comb begin
    logic hit_found, free_found;
    hit_found  = 1'b0;
    free_found = 1'b0;
    hit_sel    = '0;
    free_sel   = '0;
    lru_sel    = '0;
    hit_rank   = '0;
    hit_val    = '0;
    lru_key    = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (valid_q[i] && key_q[i] == req_i.key && !hit_found) begin
        hit_sel[i] = 1'b1;
        hit_found  = 1'b1;
      end
      if (!valid_q[i] && !free_found) begin
        free_sel[i] = 1'b1;
        free_found  = 1'b1;
      end
      lru_sel[i] = valid_q[i] && rank_q[i] == lru_rank;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      hit_rank = hit_rank | (rank_q[i] & {RANK_W{hit_sel[i]}});
      hit_val  = hit_val  | (val_q[i]  & {VAL_W{hit_sel[i]}});
      lru_key  = lru_key  | (key_q[i]  & {KEY_W{lru_sel[i]}});
    end
    hit = hit_found;
  end

  assign put_hit   = req_i.valid && req_i.mode == MODE_PUT && hit;
  assign do_insert = req_i.valid && req_i.mode == MODE_PUT && !hit;
  assign do_evict  = do_insert && full;
  assign ins_sel   = do_evict ? lru_sel : free_sel;

  // Next ranks, valid bits and occupancy
  always_comb begin
    valid_d = valid_q;
    occ_d   = occ_q;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_d[i] = rank_q[i];
    end
    if (req_i.valid && hit) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (hit_sel[i]) begin
          rank_d[i] = '0;
        end else if (valid_q[i] && rank_q[i] < hit_rank) begin
          rank_d[i] = rank_q[i] + RANK_W'(1);
        end
      end
    end else if (do_insert) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (ins_sel[i]) begin
          rank_d[i] = '0;
        end else if (valid_q[i]) begin
          rank_d[i] = rank_q[i] + RANK_W'(1);
        end
      end
      valid_d = valid_q | ins_sel;
      if (!do_evict) begin
        occ_d = occ_q + OCC_W'(1);
      end
    end
  end

  // Control state: a capacity write clears the store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CAP_RESET;
      valid_q <= '0;
      occ_q   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      cap_q   <= cfg_wdata_i;
      valid_q <= '0;
      occ_q   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      occ_q   <= occ_d;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  // Entry payload: write key and value on insert, value on put hit
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (do_insert && ins_sel[i]) begin
        key_q[i] <= req_i.key;
        val_q[i] <= req_i.value;
      end else if (put_hit && hit_sel[i]) begin
        val_q[i] <= req_i.value;
      end
    end
  end

  // Shape the response
  always_comb begin
    rsp_o.hit         = hit;
    rsp_o.evicted     = do_evict;
    rsp_o.evicted_key = do_evict ? lru_key : '0;
    if (req_i.mode == MODE_PUT) begin
      rsp_o.read_value = '0;
    end else if (hit) begin
      rsp_o.read_value = hit_val;
    end else begin
      rsp_o.read_value = MISS_VALUE;
    end
  end

endmodule

/* rtl/lru_key_value_cache.sv */
// Top level of the fully associative LRU key-value cache.
// A request is taken on every cycle that start_i is high (busy_o stays low: the
// store needs no clearing pass, since valid bits sit in flip-flops). Each request
// passes through an input register and then, through a combinational key compare and
// rank update over all entries, into the result register. done_o rises in the cycle
// after the item is taken, and one result follows per cycle. The result is shown for
// exactly one cycle and cannot be held off. Writing the capacity register clears all
// entries at once; write it only while no request is in flight.
module lru_key_value_cache #(
  parameter int ENTRIES = lrukv_pkg::DEFAULT_ENTRIES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        mode_i,
  input  logic signed [lrukv_pkg::KEY_W-1:0] key_i,
  input  logic signed [lrukv_pkg::VAL_W-1:0] value_i,
  input  logic                        cfg_we_i,
  input  logic [lrukv_pkg::CAP_W-1:0] cfg_wdata_i,
  output logic                        done_o,
  output logic                        hit_o,
  output logic signed [lrukv_pkg::VAL_W-1:0] read_value_o,
  output logic                        evicted_o,
  output logic signed [lrukv_pkg::KEY_W-1:0] evicted_key_o
);
  import lrukv_pkg::*;

  req_t             req_q;
  rsp_t             rsp;
  logic             done_q;
  logic             hit_q, evicted_q;
  logic [VAL_W-1:0] read_value_q;
  logic [KEY_W-1:0] evicted_key_q;

  assign busy_o = 1'b0;

  // Capture an item whenever one is offered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q.valid <= 1'b0;
      req_q.mode  <= MODE_GET;
      req_q.key   <= '0;
      req_q.value <= '0;
    end else begin
      req_q.valid <= start_i && !busy_o;
      req_q.mode  <= mode_e'(mode_i);
      req_q.key   <= key_i;
      req_q.value <= value_i;
    end
  end

  lrukv_store #(
    .ENTRIES(ENTRIES)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_q),
    .rsp_o      (rsp)
  );

  // Register the result and pulse the strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= req_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q         <= rsp.hit;
    read_value_q  <= rsp.read_value;
    evicted_q     <= rsp.evicted;
    evicted_key_q <= rsp.evicted_key;
  end

  assign done_o        = done_q;
  assign hit_o         = hit_q;
  assign read_value_o  = read_value_q;
  assign evicted_o     = evicted_q;
  assign evicted_key_o = evicted_key_q;

endmodule

/* sim/lru_key_value_cache_check.sv */
// Checker for the LRU key-value cache: predicts each result and compares it with the block.
module lru_key_value_cache_check #(
  parameter int ENTRIES = lrukv_pkg::DEFAULT_ENTRIES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  logic                          mode_i,
  input  logic [lrukv_pkg::KEY_W-1:0]   key_i,
  input  logic [lrukv_pkg::VAL_W-1:0]   value_i,
  input  logic                          cfg_we_i,
  input  logic [lrukv_pkg::CAP_W-1:0]   cfg_wdata_i,
  input  logic                          done_i,
  input  logic                          hit_i,
  input  logic [lrukv_pkg::VAL_W-1:0]   read_value_i,
  input  logic                          evicted_i,
  input  logic [lrukv_pkg::KEY_W-1:0]   evicted_key_i,
  output int                            mismatches_o,
  output int                            pending_o,
  output int                            results_o,
  output int                            hits_o,
  output int                            evictions_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import lrukv_pkg::*;

  // Shadow copy of the store
  logic [KEY_W-1:0] slot_key [ENTRIES];
  logic [VAL_W-1:0] slot_val [ENTRIES];
  bit               slot_used [ENTRIES];
  int unsigned      slot_age [ENTRIES];
  int unsigned      fill;
  logic [CAP_W-1:0] cap_setting;

  rsp_t predicted_rsp_q [$];

  // Drop every entry
  function automatic void clear_store();
    for (int i = 0; i < ENTRIES; i++) begin
      slot_key[i]  = '0;
      slot_val[i]  = '0;
      slot_used[i] = 1'b0;
      slot_age[i]  = 0;
    end
    fill = 0;
  endfunction

  // Make slot s the newest: valid entries newer than limit age by one
  function automatic void make_newest(int s, int unsigned limit);
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_used[i] && i != s && slot_age[i] < limit) slot_age[i]++;
    end
    slot_age[s] = 0;
  endfunction

  // Look up one request, update the shadow store and return its result
  function automatic rsp_t serve_request(mode_e kind, logic [KEY_W-1:0] k,
                                         logic [VAL_W-1:0] v);
    rsp_t        rsp;
    int          slot;
    int unsigned room;
    rsp  = '0;
    slot = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot < 0 && slot_used[i] && slot_key[i] == k) slot = i;
    end
    if (slot >= 0) begin
      rsp.hit = 1'b1;
      make_newest(slot, slot_age[slot]);
      if (kind == MODE_GET) rsp.read_value = slot_val[slot];
      else slot_val[slot] = v;
    end else if (kind == MODE_GET) begin
      rsp.read_value = MISS_VALUE;
    end else begin
      // Zero acts as one, anything above the entry count saturates
      room = (cap_setting == 0) ? 1 : ((cap_setting > ENTRIES) ? ENTRIES : cap_setting);
      if (fill < room) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot < 0 && !slot_used[i]) slot = i;
        end
      end
      // Store full: evict the oldest entry, first slot wins a tie
      if (slot < 0) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_used[i] && (slot < 0 || slot_age[i] > slot_age[slot])) slot = i;
        end
        if (slot >= 0) begin
          rsp.evicted     = 1'b1;
          rsp.evicted_key = slot_key[slot];
          slot_used[slot] = 1'b0;
          if (fill > 0) fill--;
        end
      end
      if (slot >= 0) begin
        make_newest(slot, 32'hFFFF_FFFF);
        slot_key[slot]  = k;
        slot_val[slot]  = v;
        slot_used[slot] = 1'b1;
        fill++;
      end
    end
    return rsp;
  endfunction

  // Compare the result shown this cycle, then take config writes and new items
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t exp_rsp;
    rsp_t got_rsp;
    if (!rst_ni) begin
      cap_setting = CAP_RESET;
      clear_store();
      predicted_rsp_q.delete();
      mismatches_o = 0;
      results_o    = 0;
      hits_o       = 0;
      evictions_o  = 0;
    end else begin
      if (done_i) begin
        got_rsp.hit         = hit_i;
        got_rsp.read_value  = read_value_i;
        got_rsp.evicted     = evicted_i;
        got_rsp.evicted_key = evicted_key_i;
        results_o++;
        if (hit_i) hits_o++;
        if (evicted_i) evictions_o++;
        if (predicted_rsp_q.size() == 0) begin
          if (mismatches_o < 10)
            $display("%0t: result %0d arrived with no request outstanding",
                     $time, results_o);
          mismatches_o++;
        end else begin
          exp_rsp = predicted_rsp_q.pop_front();
          if (got_rsp.hit !== exp_rsp.hit || got_rsp.read_value !== exp_rsp.read_value ||
              got_rsp.evicted !== exp_rsp.evicted ||
              got_rsp.evicted_key !== exp_rsp.evicted_key) begin
            if (mismatches_o < 10)
              $display({"%0t: result %0d exp hit=%0b rd=%h ev=%0b evk=%h,",
                        " got hit=%0b rd=%h ev=%0b evk=%h"},
                       $time, results_o, exp_rsp.hit, exp_rsp.read_value, exp_rsp.evicted,
                       exp_rsp.evicted_key, got_rsp.hit, got_rsp.read_value, got_rsp.evicted,
                       got_rsp.evicted_key);
            mismatches_o++;
          end
        end
      end
      if (cfg_we_i) begin
        cap_setting = cfg_wdata_i;
        clear_store();
      end
      if (start_i && !busy_i)
        predicted_rsp_q.push_back(serve_request(mode_e'(mode_i), key_i, value_i));
    end
    pending_o = predicted_rsp_q.size();
  end

endmodule

/* sim/lru_key_value_cache_test.sv */
// Top of the LRU key-value cache testbench: clock, reset, requests, capacity writes and verdict.
module lru_key_value_cache_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lrukv_pkg::*;

  localparam int ENTRIES      = DEFAULT_ENTRIES;
  localparam int RANDOM_ITEMS = 1730;
  localparam int PHASES       = 9;
  localparam logic [CAP_W-1:0] PHASE_CAPS [PHASES-1] =
    '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd7, 5'd17, 5'd16};

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic                    mode;
  logic signed [KEY_W-1:0] key;
  logic signed [VAL_W-1:0] value;
  logic                    cfg_we;
  logic [CAP_W-1:0]        cfg_wdata;
  logic                    done;
  logic                    hit;
  logic signed [VAL_W-1:0] read_value;
  logic                    evicted;
  logic signed [KEY_W-1:0] evicted_key;

  int mismatches;
  int pending;
  int results;
  int hits;
  int evictions;
  int requests_sent;
  int settings_run;
  bit steady;

  lru_key_value_cache #(.ENTRIES(ENTRIES)) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start_i       (start),
    .busy_o        (busy),
    .mode_i        (mode),
    .key_i         (key),
    .value_i       (value),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .done_o        (done),
    .hit_o         (hit),
    .read_value_o  (read_value),
    .evicted_o     (evicted),
    .evicted_key_o (evicted_key)
  );

  lru_key_value_cache_check #(.ENTRIES(ENTRIES)) checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start_i       (start),
    .busy_i        (busy),
    .mode_i        (mode),
    .key_i         (key),
    .value_i       (value),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .done_i        (done),
    .hit_i         (hit),
    .read_value_i  (read_value),
    .evicted_i     (evicted),
    .evicted_key_i (evicted_key),
    .mismatches_o  (mismatches),
    .pending_o     (pending),
    .results_o     (results),
    .hits_o        (hits),
    .evictions_o   (evictions)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    #5ms;
    $display("lru_key_value_cache test failed");
    $finish;
  end

  // Drive one item, hold it until taken, then sometimes idle for a random gap
  task automatic send_request(input mode_e m, input logic [KEY_W-1:0] k,
                              input logic [VAL_W-1:0] v);
    int gap;
    int r;
    start <= 1'b1;
    mode  <= m;
    key   <= k;
    value <= v;
    do @(posedge clk); while (busy);
    @(negedge clk);
    requests_sent++;
    r = $urandom_range(0, 99);
    if (steady || r < 55) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(4, 25);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Write the capacity once every outstanding result is back
  task automatic write_capacity(input logic [CAP_W-1:0] c);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= c;
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  // Random requests over a key pool a little larger than the capacity
  task automatic run_phase(input logic [CAP_W-1:0] cap, input int n);
    logic [KEY_W-1:0] key_pool [32];
    int               pool_n;
    logic [KEY_W-1:0] k;
    logic [VAL_W-1:0] v;
    mode_e            m;
    write_capacity(cap);
    pool_n = ((cap == 0) ? 1 : ((cap > ENTRIES) ? ENTRIES : cap)) + 1 + $urandom_range(0, 6);
    for (int i = 0; i < pool_n; i++) begin
      case ($urandom_range(0, 9))
        0:       key_pool[i] = 32'h8000_0000;
        1:       key_pool[i] = 32'h7FFF_FFFF;
        2:       key_pool[i] = (i > 0) ? key_pool[i-1] ^ (32'd1 << $urandom_range(0, 31)) : '0;
        3:       key_pool[i] = '1;
        default: key_pool[i] = $urandom;
      endcase
    end
    for (int j = 0; j < n; j++) begin
      // Switch between gapped and back-to-back stretches
      if (j % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      m = ($urandom_range(0, 99) < 55) ? MODE_PUT : MODE_GET;
      k = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, pool_n - 1)];
      case ($urandom_range(0, 15))
        0:       v = '0;
        1:       v = '1;
        2:       v = 32'h8000_0000;
        3:       v = 32'h7FFF_FFFF;
        default: v = $urandom;
      endcase
      send_request(m, k, v);
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    mode          = 1'b0;
    key           = '0;
    value         = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    steady        = 1'b0;
    requests_sent = 0;
    settings_run  = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset capacity: empty lookup, extreme keys and values, overwrite
    send_request(MODE_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(MODE_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(MODE_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(MODE_PUT, 32'h0000_0000, 32'h0000_0000);
    send_request(MODE_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(MODE_GET, 32'h8000_0000, 32'h1111_1111);
    send_request(MODE_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(MODE_PUT, 32'h7FFF_FFFF, 32'h1234_5678);
    send_request(MODE_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_request(MODE_GET, 32'hFFFF_FFFE, 32'h0000_0000);

    // Two entries: a get refreshes the older key, so the other one goes
    write_capacity(5'd2);
    send_request(MODE_PUT, 32'd1, 32'd11);
    send_request(MODE_PUT, 32'd2, 32'd22);
    send_request(MODE_GET, 32'd1, 32'd0);
    send_request(MODE_PUT, 32'd3, 32'd33);
    send_request(MODE_GET, 32'd2, 32'd0);
    send_request(MODE_PUT, 32'd2, 32'd44);
    send_request(MODE_GET, 32'd3, 32'd0);

    // Capacity zero behaves as a single entry
    write_capacity(5'd0);
    send_request(MODE_PUT, 32'd5, 32'd55);
    send_request(MODE_PUT, 32'd6, 32'd66);
    send_request(MODE_GET, 32'd6, 32'd0);
    send_request(MODE_PUT, 32'd6, 32'd77);

    for (int p = 0; p < PHASES; p++)
      run_phase((p < PHASES - 1) ? PHASE_CAPS[p] : CAP_W'($urandom_range(0, 31)),
                RANDOM_ITEMS / PHASES);

    // Drain the pipeline and give stray results a chance to show up
    start <= 1'b0;
    for (int w = 0; w < 100 && pending != 0; w++) @(negedge clk);
    repeat (4) @(negedge clk);

    $display("Sent %0d requests across %0d capacity settings after the reset one.",
             requests_sent, settings_run);
    $display("Checked %0d results: %0d hits, %0d evictions, %0d mismatches, %0d missing.",
             results, hits, evictions, mismatches, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("lru_key_value_cache test passed");
    end else begin
      $display("lru_key_value_cache test failed");
    end
    $finish;
  end

endmodule
